// ----- design/wmf_pkg.sv -----
// Shared types and constants of the 3x3 mean / median window filter.
// Used by wmf_filter, wmf_outq and window_3x3_mean_median_filter; no dependencies.

package wmf_pkg;

  // Frame geometry and field widths.
  localparam int unsigned MAX_WIDTH   = 1024;
  localparam int unsigned PIX_W       = 8;
  localparam int unsigned ROW_W       = 16;
  localparam int unsigned COL_W       = $clog2(MAX_WIDTH);
  localparam int unsigned WID_W       = 11;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_IDX_W   = 2;

  // Mean of nine: sum times 7282 / 2^16 is exact floor(sum / 9) for sums up to 9 * 255.
  localparam int unsigned SUM_W       = 12;
  localparam int unsigned RECIP_W     = 13;
  localparam int unsigned MEAN_RECIP  = 7282;
  localparam int unsigned MEAN_SHIFT  = 16;

  // Result queue, one entry per input pixel that yields results.
  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_e;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [8:0]       window_t;

  // Both filter results for one window.
  typedef struct packed {
    pix_t mean;
    pix_t median;
  } filt_t;

  // Up to three results caused by one input pixel.
  typedef struct packed {
    logic              en_a;   // filtered or border pixel at (r-1, c-1)
    logic              en_b;   // right border pixel at (r-1, W-1)
    logic              en_c;   // bottom row pixel at (r, c)
    logic              eof;
    pix_t              val_a;
    pix_t              val_b;
    pix_t              val_c;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [COL_W-1:0]  wm1;
  } rec_t;

endpackage

// ----- design/wmf_filter.sv -----
// Two-stage pipelined 3x3 mean and median datapath with a combinational final step.
// Depends on wmf_pkg.

module wmf_filter (
  input  logic            clk_i,
  input  wmf_pkg::window_t win_i,
  output wmf_pkg::filt_t   res_o
);

  // Sorts three values; returns {high, middle, low}.
  function automatic logic [3*wmf_pkg::PIX_W-1:0] sort3(input wmf_pkg::pix_t a,
                                                        input wmf_pkg::pix_t b,
                                                        input wmf_pkg::pix_t c);
    wmf_pkg::pix_t lo;
    wmf_pkg::pix_t mid;
    wmf_pkg::pix_t hi;
    wmf_pkg::pix_t t;
    lo  = a;
    mid = b;
    hi  = c;
    if (lo > mid) begin
      t = lo; lo = mid; mid = t;
    end
    if (mid > hi) begin
      t = mid; mid = hi; hi = t;
    end
    if (lo > mid) begin
      t = lo; lo = mid; mid = t;
    end
    return {hi, mid, lo};
  endfunction

  function automatic wmf_pkg::pix_t med3(input wmf_pkg::pix_t a, input wmf_pkg::pix_t b,
                                         input wmf_pkg::pix_t c);
    wmf_pkg::pix_t mn;
    wmf_pkg::pix_t mx;
    wmf_pkg::pix_t m2;
    mn = (a < b) ? a : b;
    mx = (a < b) ? b : a;
    m2 = (mx < c) ? mx : c;
    return (mn > m2) ? mn : m2;
  endfunction

  function automatic wmf_pkg::pix_t max3(input wmf_pkg::pix_t a, input wmf_pkg::pix_t b,
                                         input wmf_pkg::pix_t c);
    wmf_pkg::pix_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic wmf_pkg::pix_t min3(input wmf_pkg::pix_t a, input wmf_pkg::pix_t b,
                                         input wmf_pkg::pix_t c);
    wmf_pkg::pix_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  localparam int unsigned RSUM_W = wmf_pkg::PIX_W + 2;
  localparam int unsigned PROD_W = wmf_pkg::SUM_W + wmf_pkg::RECIP_W;

  wmf_pkg::pix_t     lo_d  [3];
  wmf_pkg::pix_t     mid_d [3];
  wmf_pkg::pix_t     hi_d  [3];
  logic [RSUM_W-1:0] rsum_d [3];
  wmf_pkg::pix_t     lo_q  [3];
  wmf_pkg::pix_t     mid_q [3];
  wmf_pkg::pix_t     hi_q  [3];
  logic [RSUM_W-1:0] rsum_q [3];

  wmf_pkg::pix_t            mxlo_q;
  wmf_pkg::pix_t            mdmid_q;
  wmf_pkg::pix_t            mnhi_q;
  logic [wmf_pkg::SUM_W-1:0] total_q;
  logic [PROD_W-1:0]        prod;

  // First stage: sort and add each row of the window.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      {hi_d[i], mid_d[i], lo_d[i]} = sort3(win_i[3*i], win_i[3*i+1], win_i[3*i+2]);
      rsum_d[i] = RSUM_W'(win_i[3*i]) + RSUM_W'(win_i[3*i+1]) + RSUM_W'(win_i[3*i+2]);
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    mid_q  <= mid_d;
    hi_q   <= hi_d;
    rsum_q <= rsum_d;
  end

  // Second stage: the median candidates and the total of nine.
  always_ff @(posedge clk_i) begin
    mxlo_q  <= max3(lo_q[0], lo_q[1], lo_q[2]);
    mdmid_q <= med3(mid_q[0], mid_q[1], mid_q[2]);
    mnhi_q  <= min3(hi_q[0], hi_q[1], hi_q[2]);
    total_q <= wmf_pkg::SUM_W'(rsum_q[0]) + wmf_pkg::SUM_W'(rsum_q[1])
             + wmf_pkg::SUM_W'(rsum_q[2]);
  end

  // Final step: median of the candidates, and division by nine through a reciprocal.
  assign prod = PROD_W'(total_q) * PROD_W'(wmf_pkg::RECIP_W'(wmf_pkg::MEAN_RECIP));
  assign res_o.median = med3(mxlo_q, mdmid_q, mnhi_q);
  assign res_o.mean   = prod[wmf_pkg::MEAN_SHIFT +: wmf_pkg::PIX_W];

endmodule

// ----- design/wmf_outq.sv -----
// Result queue: holds one record per input pixel and hands out its results one per transfer.
// Depends on wmf_pkg.

module wmf_outq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  wmf_pkg::rec_t               rec_i,
  output logic [wmf_pkg::QCNT_W-1:0]  cnt_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [wmf_pkg::PIX_W-1:0]   pixel_out_o,
  output logic [wmf_pkg::ROW_W-1:0]   out_row_o,
  output logic [wmf_pkg::COL_W-1:0]   out_col_o,
  output logic                        last_of_step_o,
  output logic                        end_of_frame_o
);

  localparam int unsigned PTR_W = $clog2(wmf_pkg::QUEUE_DEPTH);

  wmf_pkg::rec_t q_mem [wmf_pkg::QUEUE_DEPTH];

  logic [PTR_W-1:0]          wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]          rd_ptr_q, rd_ptr_d;
  logic [wmf_pkg::QCNT_W-1:0] cnt_q, cnt_d;
  logic [2:0]                done_q, done_d;

  wmf_pkg::rec_t head;
  logic [2:0]    pend;
  logic [2:0]    sel;
  logic          last;
  logic          xfer;
  logic          pop;

  // Storage of the records.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      q_mem[wr_ptr_q] <= rec_i;
    end
  end

  // Pick the first result of the head record not yet transferred.
  assign head = q_mem[rd_ptr_q];
  assign pend = {head.en_c, head.en_b, head.en_a} & ~done_q;

  always_comb begin
    if (pend[0]) begin
      sel = 3'b001;
    end else if (pend[1]) begin
      sel = 3'b010;
    end else begin
      sel = 3'b100;
    end
  end

  assign last = (pend & ~sel) == 3'b000;

  // Output fields of the selected result.
  always_comb begin
    pixel_out_o = head.val_c;
    out_row_o   = head.row;
    out_col_o   = head.col;
    if (sel[0]) begin
      pixel_out_o = head.val_a;
      out_row_o   = head.row - wmf_pkg::ROW_W'(1);
      out_col_o   = head.col - wmf_pkg::COL_W'(1);
    end else if (sel[1]) begin
      pixel_out_o = head.val_b;
      out_row_o   = head.row - wmf_pkg::ROW_W'(1);
      out_col_o   = head.wm1;
    end
  end

  assign out_valid_o    = cnt_q != '0;
  assign last_of_step_o = last;
  assign end_of_frame_o = sel[2] && head.eof;
  assign cnt_o          = cnt_q;

  assign xfer = out_valid_o && !out_stall_i;
  assign pop  = xfer && last;

  // Pointer, fill and progress bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    done_d   = done_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(wmf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(wmf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      done_d   = '0;
    end else if (xfer) begin
      done_d = done_q | sel;
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + wmf_pkg::QCNT_W'(1);
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - wmf_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      done_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
      done_q   <= done_d;
    end
  end

endmodule

// ----- design/window_3x3_mean_median_filter.sv -----
// Top level of the 3x3 mean / median window filter: line store, window, counters, config.
// Depends on wmf_pkg, wmf_filter and wmf_outq.

// The block takes one 8-bit pixel per clock in raster order and gives each pixel back, one
// row and one column late, as the mean or median of its 3x3 neighbourhood, with the frame
// border passed through unchanged. Every result carries its row and column. A pixel that
// causes at most one result is taken in every clock while the output is not stalled; at a
// row end, and along the bottom row, a pixel causes two or three results and the input then
// follows the output port, which moves one result per clock unless stalled. A result passes
// the line store read, the window register, the sort and sum pipeline and the result queue
// before it is offered. The two previous rows share one 1024 x 16-bit single-port-read
// memory, read when a pixel arrives and written back in the next clock; for a one-pixel-wide
// frame the written word is forwarded. The line store is not cleared after reset, so the
// block is ready at once. Writing the width or height register starts a new frame.

module window_3x3_mean_median_filter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [wmf_pkg::PIX_W-1:0]      pixel_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [wmf_pkg::PIX_W-1:0]      pixel_out_o,
  output logic [wmf_pkg::ROW_W-1:0]      out_row_o,
  output logic [wmf_pkg::COL_W-1:0]      out_col_o,
  output logic                           last_of_step_o,
  output logic                           end_of_frame_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [wmf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wmf_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned LINE_W = 2 * wmf_pkg::PIX_W;
  localparam int unsigned LOAD_W = wmf_pkg::QCNT_W + 1;

  // One pixel on its way through the pipeline.
  typedef struct packed {
    logic                      en_a;
    logic                      pass_a;
    logic                      en_b;
    logic                      en_c;
    logic                      eof;
    wmf_pkg::pix_t             centre;
    wmf_pkg::pix_t             right;
    wmf_pkg::pix_t             pixel;
    logic [wmf_pkg::ROW_W-1:0] row;
    logic [wmf_pkg::COL_W-1:0] col;
    logic [wmf_pkg::COL_W-1:0] wm1;
  } stage_t;

  // Configuration and position.
  logic                      mode_q, mode_d;
  logic [wmf_pkg::WID_W-1:0] width_q, width_d;
  logic [wmf_pkg::ROW_W-1:0] height_q, height_d;
  logic [wmf_pkg::ROW_W-1:0] row_q, row_d;
  logic [wmf_pkg::COL_W-1:0] col_q, col_d;

  logic [wmf_pkg::WID_W-1:0] eff_w;
  logic [wmf_pkg::ROW_W-1:0] eff_h;
  logic [wmf_pkg::ROW_W-1:0] r_eff;
  logic [wmf_pkg::COL_W-1:0] c_eff;
  logic [wmf_pkg::WID_W-1:0] c_inc;
  logic [wmf_pkg::ROW_W:0]   r_inc;
  logic                      col_last;
  logic                      accept;
  stage_t                    st0;

  // Line store, {older row, newer row} per column.
  logic [LINE_W-1:0] line_mem [wmf_pkg::MAX_WIDTH];
  logic [LINE_W-1:0] rd_q;
  logic [LINE_W-1:0] line_rd;
  logic [LINE_W-1:0] wr_data;
  logic              fwd_q, fwd_d;
  logic [LINE_W-1:0] fwd_data_q;

  // Pipeline.
  logic             v1_q, v2_q, v3_q, v4_q;
  stage_t           st1_q, st2_q, st3_q, st4_q;
  stage_t           st2_d;
  wmf_pkg::window_t window_q, window_d;
  wmf_pkg::pix_t    up1;
  wmf_pkg::pix_t    up2;
  wmf_pkg::filt_t   filt;
  wmf_pkg::rec_t    rec;
  logic             push;
  logic [wmf_pkg::QCNT_W-1:0] q_cnt;
  logic [LOAD_W-1:0] load;

  // Effective frame size.
  always_comb begin
    if (width_q == '0) begin
      eff_w = wmf_pkg::WID_W'(1);
    end else if (width_q > wmf_pkg::WID_W'(wmf_pkg::MAX_WIDTH)) begin
      eff_w = wmf_pkg::WID_W'(wmf_pkg::MAX_WIDTH);
    end else begin
      eff_w = width_q;
    end
  end

  assign eff_h = (height_q == '0) ? wmf_pkg::ROW_W'(1) : height_q;

  // Position of the arriving pixel and the results it causes.
  assign r_eff    = (row_q >= eff_h) ? '0 : row_q;
  assign c_eff    = ({1'b0, col_q} >= eff_w) ? '0 : col_q;
  assign col_last = {1'b0, c_eff} == (eff_w - wmf_pkg::WID_W'(1));
  assign c_inc    = {1'b0, c_eff} + wmf_pkg::WID_W'(1);
  assign r_inc    = {1'b0, r_eff} + (wmf_pkg::ROW_W + 1)'(1);

  always_comb begin
    st0        = '0;
    st0.en_a   = (r_eff != '0) && (c_eff != '0);
    st0.pass_a = (r_eff == wmf_pkg::ROW_W'(1)) || (c_eff == wmf_pkg::COL_W'(1));
    st0.en_b   = (r_eff != '0) && col_last;
    st0.en_c   = r_eff == (eff_h - wmf_pkg::ROW_W'(1));
    st0.eof    = col_last;
    st0.pixel  = pixel_in_i;
    st0.row    = r_eff;
    st0.col    = c_eff;
    st0.wm1    = wmf_pkg::COL_W'(eff_w - wmf_pkg::WID_W'(1));
  end

  // Input flow control: room in the queue for every pixel already in flight.
  assign load = LOAD_W'(q_cnt) + LOAD_W'(v1_q) + LOAD_W'(v2_q) + LOAD_W'(v3_q)
              + LOAD_W'(v4_q);
  assign in_stall_o = load >= LOAD_W'(wmf_pkg::QUEUE_DEPTH);
  assign accept     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Register writes and position counters.
  always_comb begin
    mode_d   = mode_q;
    width_d  = width_q;
    height_d = height_q;
    row_d    = row_q;
    col_d    = col_q;
    if (accept) begin
      if (c_inc >= eff_w) begin
        col_d = '0;
        row_d = (r_inc >= {1'b0, eff_h}) ? '0 : r_inc[wmf_pkg::ROW_W-1:0];
      end else begin
        col_d = c_inc[wmf_pkg::COL_W-1:0];
        row_d = r_eff;
      end
    end
    if (cfg_valid_i) begin
      case (wmf_pkg::cfg_idx_e'(cfg_index_i))
        wmf_pkg::CFG_MODE: begin
          mode_d = cfg_data_i[0];
        end
        wmf_pkg::CFG_WIDTH: begin
          width_d = cfg_data_i[wmf_pkg::WID_W-1:0];
          row_d   = '0;
          col_d   = '0;
        end
        wmf_pkg::CFG_HEIGHT: begin
          height_d = cfg_data_i[wmf_pkg::ROW_W-1:0];
          row_d    = '0;
          col_d    = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      width_q  <= wmf_pkg::WID_W'(1024);
      height_q <= wmf_pkg::ROW_W'(1024);
      row_q    <= '0;
      col_q    <= '0;
    end else begin
      mode_q   <= mode_d;
      width_q  <= width_d;
      height_q <= height_d;
      row_q    <= row_d;
      col_q    <= col_d;
    end
  end

  // Line store read on transfer, write-back in the next clock.
  assign line_rd = fwd_q ? fwd_data_q : rd_q;
  assign up2     = line_rd[LINE_W-1 -: wmf_pkg::PIX_W];
  assign up1     = line_rd[wmf_pkg::PIX_W-1:0];
  assign wr_data = {up1, st1_q.pixel};
  assign fwd_d   = accept && v1_q && (st1_q.col == c_eff);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= line_mem[c_eff];
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      line_mem[st1_q.col] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= wr_data;
  end

  // Window shift: the new column enters on the right.
  always_comb begin
    window_d = window_q;
    st2_d    = st1_q;
    if (v1_q) begin
      for (int i = 0; i < 3; i++) begin
        window_d[3*i]   = window_q[3*i+1];
        window_d[3*i+1] = window_q[3*i+2];
      end
      window_d[2] = up2;
      window_d[5] = up1;
      window_d[8] = st1_q.pixel;
    end
    st2_d.centre = window_q[5];
    st2_d.right  = up1;
  end

  always_ff @(posedge clk_i) begin
    window_q <= window_d;
    st1_q    <= st0;
    st2_q    <= st2_d;
    st3_q    <= st2_q;
    st4_q    <= st3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      fwd_q <= 1'b0;
    end else begin
      v1_q  <= accept;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= v3_q;
      fwd_q <= fwd_d;
    end
  end

  // Mean and median of the window.
  wmf_filter u_filter (
    .clk_i (clk_i),
    .win_i (window_q),
    .res_o (filt)
  );

  // Assemble the results of one pixel.
  always_comb begin
    rec       = '0;
    rec.en_a  = st4_q.en_a;
    rec.en_b  = st4_q.en_b;
    rec.en_c  = st4_q.en_c;
    rec.eof   = st4_q.eof;
    rec.val_a = st4_q.pass_a ? st4_q.centre : (mode_q ? filt.median : filt.mean);
    rec.val_b = st4_q.right;
    rec.val_c = st4_q.pixel;
    rec.row   = st4_q.row;
    rec.col   = st4_q.col;
    rec.wm1   = st4_q.wm1;
  end

  assign push = v4_q && (st4_q.en_a || st4_q.en_b || st4_q.en_c);

  wmf_outq u_outq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .rec_i          (rec),
    .cnt_o          (q_cnt),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_out_o    (pixel_out_o),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .last_of_step_o (last_of_step_o),
    .end_of_frame_o (end_of_frame_o)
  );

  // Forwarding is only ever needed when consecutive pixels share a column.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> (eff_w == wmf_pkg::WID_W'(1)))
    else $error("line store forwarding with a frame wider than one pixel");

  // Flow control keeps a free queue entry for every pixel leaving the pipeline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> (q_cnt != wmf_pkg::QCNT_W'(wmf_pkg::QUEUE_DEPTH)))
    else $error("result queue full while a pixel leaves the pipeline");

  // The bottom-right result always closes its pixel's group.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && end_of_frame_o) |-> last_of_step_o)
    else $error("end of frame on a result that is not the last of its group");

  // The position counters stay inside the frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, col_q} < eff_w) && (row_q < eff_h))
    else $error("position counters outside the frame");

endmodule
